FILE: hw/rtl/lbp_pkg.sv
// Shared types and constants for the 3x3 local binary pattern operator.
// Used by lbp_3x3_operator; no dependencies.
package lbp_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_operation;

    // one window column: rows above, at and below the center row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // line store entry: the two rows above the incoming one, same column
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } t_line_pair;

endpackage

FILE: hw/rtl/lbp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on address collision; no dependencies.
module lbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lbp_3x3_operator.sv
// Streaming 3x3 local binary pattern operator, top level.
// Depends on lbp_pkg and lbp_ram.
//
// Usage:
//   Input stream (s_axis): one transfer per item. tdata carries the 8-bit
//   pixel, tuser the operation (0 = pixel, 1 = flush). Pixels arrive in
//   raster order; a frame is frame_width x frame_height pixels.
//   Output stream (m_axis): tdata carries the 8-bit pattern code, tlast
//   marks the code of the frame's last pixel.
//   Config port: write frame_width (index 0) or frame_height (index 1)
//   while the block is idle; the values apply from the next frame start.
//   Latency: the code of pixel p is registered on the edge that accepts
//   item p + width + 1 and shows on m_axis in the following cycle. After
//   the last pixel, width + 1 flush items drain the remaining codes;
//   flush items before the frame end are dropped. A one-row frame needs
//   only width flush items: the window advances one column on its own in
//   the cycle after the last pixel.
//   Throughput: one item per cycle. The window line store is a single
//   RAM read one column ahead, so each item needs one read and one write.
//   Stall: s_axis_tready drops while the output register is full and
//   m_axis_tready is low, and in the cycle after the last pixel of
//   a one-row frame; the output holds until taken.
//   Reset: synchronous, active low; frame 640 x 480, counters at frame
//   start, output empty. The line store needs no clearing.
module lbp_3x3_operator #(
    parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lbp_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    input  logic                          s_axis_tuser,   // [0] operation
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lbp_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] lbp_code
    output logic                          m_axis_tlast,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int DW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int ORW    = $clog2(MAX_HEIGHT);
    localparam int PAIR_W = $bits(lbp_pkg::t_line_pair);

    logic [lbp_pkg::CFG_W-1:0] r_cfg_w;
    logic [lbp_pkg::CFG_W-1:0] r_cfg_h;
    logic [DW-1:0]             r_act_w;
    logic [HW-1:0]             r_act_h;
    logic [CW-1:0]             r_in_col;
    logic [RW-1:0]             r_in_row;
    logic [CW-1:0]             r_out_col;
    logic [ORW-1:0]            r_out_row;
    lbp_pkg::t_column          r_col_c;
    lbp_pkg::t_column          r_col_l;
    logic                      r_fwd;
    lbp_pkg::t_line_pair       r_fwd_pair;
    logic                      r_out_valid;
    logic [lbp_pkg::PIX_W-1:0] r_out_code;
    logic                      r_out_eof;

    logic                      at_start;
    logic [DW-1:0]             clamp_w;
    logic [HW-1:0]             clamp_h;
    logic [DW-1:0]             act_w;
    logic [HW-1:0]             act_h;
    logic                      accept;
    logic                      at_drain;
    logic                      bubble;
    logic                      push;
    logic                      primed;
    logic                      emit;
    logic                      in_last_col;
    logic [CW-1:0]             next_col;
    logic                      out_first_col;
    logic                      out_last_col;
    logic                      out_first_row;
    logic                      out_last_row;
    logic                      eof;
    logic [PAIR_W-1:0]         ram_rdata;
    lbp_pkg::t_line_pair       pair_now;
    lbp_pkg::t_line_pair       wr_pair;
    lbp_pkg::t_column          col_new;
    logic [lbp_pkg::PIX_W-1:0] n_code;
    logic [lbp_pkg::PIX_W-1:0] center;

    // frame geometry, taken from the registers at frame start
    always_comb begin
        if (r_cfg_w == '0) begin
            clamp_w = DW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            clamp_w = DW'(MAX_WIDTH);
        end else begin
            clamp_w = DW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            clamp_h = HW'(1);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            clamp_h = HW'(MAX_HEIGHT);
        end else begin
            clamp_h = HW'(r_cfg_h);
        end
    end

    assign at_start = (r_in_col == '0) && (r_in_row == '0);
    assign act_w    = at_start ? clamp_w : r_act_w;
    assign act_h    = at_start ? clamp_h : r_act_h;

    // item handling; a one-row frame advances the window once on its own
    assign at_drain      = r_in_row >= RW'(act_h);
    assign primed        = (r_in_row > RW'(1)) ||
                           ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign bubble        = at_drain && !primed;
    assign s_axis_tready = (!r_out_valid || m_axis_tready) && !bubble;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = bubble || (accept &&
                           (at_drain || (s_axis_tuser == lbp_pkg::OP_PIXEL)));
    assign emit          = push && primed;

    assign in_last_col = DW'(r_in_col) == (act_w - DW'(1));
    assign next_col    = in_last_col ? '0 : r_in_col + CW'(1);

    assign out_first_col = r_out_col == '0;
    assign out_last_col  = DW'(r_out_col) == (act_w - DW'(1));
    assign out_first_row = r_out_row == '0;
    assign out_last_row  = HW'(r_out_row) == (act_h - HW'(1));
    assign eof           = out_last_col && out_last_row;

    // line store, read one column ahead of the write
    lbp_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_in_col),
        .i_wdata (wr_pair),
        .i_re    (push),
        .i_raddr (next_col),
        .o_rdata (ram_rdata)
    );

    assign pair_now    = r_fwd ? r_fwd_pair : lbp_pkg::t_line_pair'(ram_rdata);
    assign wr_pair.top = pair_now.mid;
    assign wr_pair.mid = s_axis_tdata;
    assign col_new.top = pair_now.top;
    assign col_new.mid = pair_now.mid;
    assign col_new.bot = s_axis_tdata;

    // pattern bits; neighbors outside the frame give zero
    assign center = r_col_c.mid;
    always_comb begin
        n_code[7] = !out_first_row && (center < r_col_c.top);
        n_code[6] = !out_first_row && !out_last_col && (center < col_new.top);
        n_code[5] = !out_last_col && (center < col_new.mid);
        n_code[4] = !out_last_row && !out_last_col && (center < col_new.bot);
        n_code[3] = !out_last_row && (center < r_col_c.bot);
        n_code[2] = !out_last_row && !out_first_col && (center < r_col_l.bot);
        n_code[1] = !out_first_col && (center < r_col_l.mid);
        n_code[0] = !out_first_row && !out_first_col && (center < r_col_l.top);
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= lbp_pkg::RESET_FRAME_WIDTH;
            r_cfg_h <= lbp_pkg::RESET_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            case (lbp_pkg::t_reg_index'(i_cfg_index))
                lbp_pkg::REG_FRAME_WIDTH: begin
                    r_cfg_w <= i_cfg_data;
                end
                lbp_pkg::REG_FRAME_HEIGHT: begin
                    r_cfg_h <= i_cfg_data;
                end
                default: begin
                    r_cfg_w <= r_cfg_w;
                end
            endcase
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_fwd     <= 1'b0;
        end else if (push) begin
            r_fwd <= next_col == r_in_col;
            if (emit && eof) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= next_col;
                if (in_last_col) begin
                    r_in_row <= r_in_row + RW'(1);
                end
                if (emit) begin
                    if (out_last_col) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ORW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // window columns and geometry hold
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_act_w    <= act_w;
            r_act_h    <= act_h;
            r_col_l    <= r_col_c;
            r_col_c    <= col_new;
            r_fwd_pair <= wr_pair;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_code <= n_code;
            r_out_eof  <= eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_code;
    assign m_axis_tlast  = r_out_eof;

endmodule
